// ----- rtl/core/frm_pkg.sv -----
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants of the frame rate meter: item layouts, register
// indexes, register reset values and the Q8 scale of one second.
// ----------------------------------------------------------------------------
package frm_pkg;

   localparam int TIME_BITS      = 48;
   localparam int RATE_BITS      = 24;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CSR_BITS       = 24;
   localparam int CSR_IDX_BITS   = 2;
   localparam int SRC_BITS       = 2;
   localparam int SCALE_BITS     = 28;

   localparam logic [SCALE_BITS-1:0] US_PER_SEC_Q8 = 28'd256000000;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PUBLISH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STALE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EARLY   = 2'd2;

   localparam logic [CSR_BITS-1:0] PUBLISH_RESET = 24'd500000;
   localparam logic [CSR_BITS-1:0] STALE_RESET   = 24'd1500000;
   localparam logic [CSR_BITS-1:0] EARLY_RESET   = 24'd100000;

   localparam logic [SRC_BITS-1:0] SRC_ZERO      = 2'd0;
   localparam logic [SRC_BITS-1:0] SRC_PUBLISHED = 2'd1;
   localparam logic [SRC_BITS-1:0] SRC_EARLY     = 2'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0] now_us;
      logic                 frame_seen;
   } req_type;

   typedef struct packed {
      logic [RATE_BITS-1:0] rate_q8;
      logic [SRC_BITS-1:0]  rate_source;
   } rsp_type;

endpackage

// ----- rtl/core/frm_div.sv -----
// ----------------------------------------------------------------------------
// frm_div
// Shared rate unit: scales a frame count to Q8 frames per second and divides
// it by the elapsed microseconds, one quotient bit per cycle, then saturates.
// ----------------------------------------------------------------------------
module frm_div
   import frm_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [TIME_BITS-1:0]  elapsed,
   output logic                  done,
   output logic [RATE_BITS-1:0]  rate
);

   localparam int NUM_BITS = COUNT_BITS + SCALE_BITS;
   localparam int STEP_W   = $clog2(NUM_BITS + 1);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_MUL  = 2'd1;
   localparam logic [1:0] D_RUN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]  divisor_ff, divisor_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  done_ff, done_in;
   logic [RATE_BITS-1:0]  rate_ff, rate_in;

   logic [TIME_BITS:0]    shifted;
   logic [TIME_BITS:0]    diff;
   logic                  fits;
   logic [NUM_BITS-1:0]   quot;

   assign shifted = {rem_ff, num_ff[NUM_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign quot    = {num_ff[NUM_BITS-2:0], fits};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      rate_in    = rate_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               count_in   = count;
               divisor_in = elapsed;
               state_in   = D_MUL;
            end
         end
         D_MUL: begin
            num_in  = NUM_BITS'(count_ff) * NUM_BITS'(US_PER_SEC_Q8);
            rem_in  = '0;
            step_in = STEP_W'(NUM_BITS);
            if (divisor_ff == '0) begin
               rate_in  = '0;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in  = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
            num_in  = quot;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               rate_in  = (|quot[NUM_BITS-1:RATE_BITS]) ? '1 : quot[RATE_BITS-1:0];
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff   <= count_in;
      divisor_ff <= divisor_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      rate_ff    <= rate_in;
   end

   assign done = done_ff;
   assign rate = rate_ff;

endmodule

// ----- rtl/core/frame_rate_meter.sv -----
// ----------------------------------------------------------------------------
// frame_rate_meter
// Windowed frame rate meter: records presented frames, publishes count over
// elapsed time per window and returns the current Q16.8 rate for each item.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type  (now_us, frame_seen)
//   rsp      out        rsp_valid/rsp_stall  rsp_type  (rate_q8, rate_source)
//   csr      in         csr_we               csr_index, csr_wdata
//
// An item steps through S_IDLE, S_REC, S_READ and S_OUT, and through S_DIV
// too when the bit-serial divider in frm_div computes a rate (one at most).
// Reset is synchronous, clears all window state and presets the registers.
// req_stall is high while an item is at work; one finished item waits in the
// output register while the next is accepted.
// ----------------------------------------------------------------------------
module frame_rate_meter
   import frm_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_REC  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam int PAD = TIME_BITS - CSR_BITS;

   logic [2:0]            state_ff, state_in;
   logic [CSR_BITS-1:0]   publish_ff, stale_ff, early_ff;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic                  frame_ff, frame_in;
   logic                  open_ff, open_in;
   logic [TIME_BITS-1:0]  start_ff, start_in;
   logic                  seen_ff, seen_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RATE_BITS-1:0]  pub_ff, pub_in;
   logic [TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] op_count_ff, op_count_in;
   logic                  pub_mode_ff, pub_mode_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic                  div_done;
   logic [RATE_BITS-1:0]  div_rate;
   logic [TIME_BITS-1:0]  elapsed_now;
   logic [TIME_BITS-1:0]  age;
   logic [COUNT_BITS-1:0] count_inc;

   assign elapsed_now = now_ff - start_ff;
   assign age         = now_ff - last_ff;
   assign count_inc   = (&count_ff) ? count_ff : count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         publish_ff <= PUBLISH_RESET;
         stale_ff   <= STALE_RESET;
         early_ff   <= EARLY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PUBLISH: publish_ff <= csr_wdata;
            CSR_STALE:   stale_ff   <= csr_wdata;
            CSR_EARLY:   early_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      frame_in     = frame_ff;
      open_in      = open_ff;
      start_in     = start_ff;
      seen_in      = seen_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      pub_in       = pub_ff;
      elapsed_in   = elapsed_ff;
      op_count_in  = op_count_ff;
      pub_mode_in  = pub_mode_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_data.now_us;
               frame_in = req_data.frame_seen;
               state_in = S_REC;
            end
         end
         S_REC: begin
            elapsed_in = elapsed_now;
            state_in   = S_READ;
            if (frame_ff) begin
               seen_in = 1'b1;
               last_in = now_ff;
               if (!open_ff) begin
                  open_in  = 1'b1;
                  start_in = now_ff;
                  count_in = '0;
               end else if (elapsed_now >= {{PAD{1'b0}}, publish_ff}) begin
                  op_count_in = count_inc;
                  start_in    = now_ff;
                  count_in    = '0;
                  pub_mode_in = 1'b1;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end else begin
                  count_in = count_inc;
               end
            end
         end
         S_READ: begin
            res_in   = '{rate_q8: '0, rate_source: SRC_ZERO};
            state_in = S_OUT;
            if (seen_ff && age <= {{PAD{1'b0}}, stale_ff}) begin
               if (pub_ff != '0) begin
                  res_in = '{rate_q8: pub_ff, rate_source: SRC_PUBLISHED};
               end else if (open_ff && count_ff >= COUNT_BITS'(2) &&
                            elapsed_ff >= {{PAD{1'b0}}, early_ff}) begin
                  op_count_in = count_ff;
                  pub_mode_in = 1'b0;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (pub_mode_ff) begin
                  pub_in   = div_rate;
                  state_in = S_READ;
               end else begin
                  res_in.rate_q8     = div_rate;
                  res_in.rate_source = (div_rate != '0) ? SRC_EARLY : SRC_ZERO;
                  state_in           = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         start_ff     <= '0;
         seen_ff      <= 1'b0;
         last_ff      <= '0;
         count_ff     <= '0;
         pub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         start_ff     <= start_in;
         seen_ff      <= seen_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         pub_ff       <= pub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      frame_ff    <= frame_in;
      elapsed_ff  <= elapsed_in;
      op_count_ff <= op_count_in;
      pub_mode_ff <= pub_mode_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   frm_div #(
      .COUNT_BITS(COUNT_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .count  (op_count_in),
      .elapsed(elapsed_now),
      .done   (div_done),
      .rate   (div_rate)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/sv/tb_frame_rate_meter.sv -----
// ----------------------------------------------------------------------------
// tb_frame_rate_meter
// Self-checking bench for the frame rate meter. A behavioral predictor keeps
// its own window, staleness and register state, computes the Q16.8 rate and
// its source for every accepted item, and a checker compares each result in
// order. Directed corners are followed by an output hold-off, a long window
// run and random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_frame_rate_meter;
   timeunit 1ns;
   timeprecision 1ps;
   import frm_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [63:0]             RATE_SAT   = 64'hFF_FFFF;
   localparam logic [CSR_BITS-1:0]     CSR_MAX    = 24'hFF_FFFF;
   localparam int                      SETTLE     = 64;
   localparam int                      LONG_HOLD  = 300;
   localparam longint                  LIMIT_CYCLES = 20_000_000;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_PUBLISH;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   // predictor state
   logic [CSR_BITS-1:0]       cfg_publish = PUBLISH_RESET;
   logic [CSR_BITS-1:0]       cfg_stale   = STALE_RESET;
   logic [CSR_BITS-1:0]       cfg_early   = EARLY_RESET;
   logic                      win_open    = 1'b0;
   logic [TIME_BITS-1:0]      win_start_us = '0;
   logic                      seen_any    = 1'b0;
   logic [TIME_BITS-1:0]      last_frame_us = '0;
   logic [COUNT_BITS_DEF-1:0] win_frames  = '0;
   logic [RATE_BITS-1:0]      published   = '0;

   rsp_type              expected_rates[$];
   logic [TIME_BITS-1:0] stamp_us    = '0;
   bit                   idle_on     = 1'b1;
   int                   hold_token  = 0;
   int                   hold_seen   = 0;
   int unsigned          hold_left   = 0;
   int                   mismatches  = 0;
   int                   items_sent  = 0;
   int                   csr_writes  = 0;
   longint               cycle_count = 0;

   frame_rate_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [RATE_BITS-1:0] q8_rate(logic [COUNT_BITS_DEF-1:0] frames,
                                                    logic [TIME_BITS-1:0] span);
      logic [63:0] quotient;
      if (span == '0) return '0;
      quotient = (64'(frames) * 64'(US_PER_SEC_Q8)) / 64'(span);
      return (quotient > RATE_SAT) ? RATE_SAT[RATE_BITS-1:0] : quotient[RATE_BITS-1:0];
   endfunction

   function automatic rsp_type predict_rate(req_type item);
      rsp_type              result;
      logic [TIME_BITS-1:0] span;
      result.rate_q8     = '0;
      result.rate_source = SRC_ZERO;
      if (item.frame_seen) begin
         seen_any      = 1'b1;
         last_frame_us = item.now_us;
         if (!win_open) begin
            win_open     = 1'b1;
            win_start_us = item.now_us;
            win_frames   = '0;
         end else begin
            if (win_frames != '1) win_frames++;
            span = item.now_us - win_start_us;
            if (span >= 48'(cfg_publish)) begin
               published    = q8_rate(win_frames, span);
               win_start_us = item.now_us;
               win_frames   = '0;
            end
         end
      end
      span = item.now_us - last_frame_us;
      if (seen_any && span <= 48'(cfg_stale)) begin
         if (published != '0) begin
            result.rate_q8     = published;
            result.rate_source = SRC_PUBLISHED;
         end else begin
            span = item.now_us - win_start_us;
            if (win_open && win_frames >= 2 && span >= 48'(cfg_early)) begin
               result.rate_q8     = q8_rate(win_frames, span);
               result.rate_source = (result.rate_q8 != '0) ? SRC_EARLY : SRC_ZERO;
            end
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin : rsp_side
      int unsigned draw;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_token;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         draw = idle_on ? $urandom_range(0, 7) : 0;
         hold_left <= (draw == 0) ? 0 : draw - 1;
         rsp_stall <= (draw != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rate_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rates.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, actual rate_q8 %0d source %0d",
                     $time, rsp_data.rate_q8, rsp_data.rate_source);
         end else begin
            want = expected_rates.pop_front();
            if (rsp_data.rate_q8 !== want.rate_q8) begin
               mismatches++;
               $display("%0t: rate_q8 expected %0d actual %0d",
                        $time, want.rate_q8, rsp_data.rate_q8);
            end
            if (rsp_data.rate_source !== want.rate_source) begin
               mismatches++;
               $display("%0t: rate_source expected %0d actual %0d",
                        $time, want.rate_source, rsp_data.rate_source);
            end
         end
      end
   end

   task automatic send_item(logic [TIME_BITS-1:0] when, logic frame);
      req_type     item;
      int unsigned gap;
      item.now_us     = when;
      item.frame_seen = frame;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      stamp_us = when;
      expected_rates.push_back(predict_rate(item));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PUBLISH: cfg_publish = value;
         CSR_STALE:   cfg_stale   = value;
         CSR_EARLY:   cfg_early   = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic test_window_lifecycle();
      send_item(48'd0, 1'b0);
      send_item(48'd0, 1'b1);
      send_item(48'd50000, 1'b1);
      send_item(48'd99999, 1'b1);
      send_item(48'd100000, 1'b0);
      send_item(48'd500000, 1'b1);
      send_item(48'd2000000, 1'b0);
      send_item(48'd2000001, 1'b0);
      send_item(48'd2000001, 1'b1);
      send_item(48'd302000001, 1'b1);
      send_item(48'd302000002, 1'b0);
   endtask

   task automatic test_zero_registers();
      wait_for_results();
      write_csr(CSR_PUBLISH, '0);
      write_csr(CSR_STALE, '0);
      write_csr(CSR_EARLY, '0);
      write_csr(CSR_UNUSED, CSR_MAX);
      send_item(48'd400000000, 1'b1);
      send_item(48'd400000000, 1'b1);
      send_item(48'd400000000, 1'b0);
      send_item(48'd400000001, 1'b0);
   endtask

   task automatic test_saturation_and_wrap();
      wait_for_results();
      write_csr(CSR_PUBLISH, CSR_MAX);
      write_csr(CSR_STALE, CSR_MAX);
      write_csr(CSR_EARLY, 24'd1);
      send_item(48'hFFFF_FFFF_FFFE, 1'b1);
      send_item(48'hFFFF_FFFF_FFFF, 1'b1);
      send_item(48'd0, 1'b1);
      send_item(48'd1, 1'b0);
   endtask

   task automatic test_backpressure();
      int n;
      wait_for_results();
      idle_on = 1'b0;
      hold_token <= hold_token + 1;
      for (n = 0; n < 16; n++)
         send_item(stamp_us + 48'($urandom_range(0, 40000)), $urandom_range(0, 3) != 0);
      wait_for_results();
      idle_on = 1'b1;
      for (n = 0; n < 8; n++)
         send_item(stamp_us + 48'($urandom_range(0, 40000)), 1'b1);
   endtask

   task automatic test_long_window();
      int                   n;
      logic [TIME_BITS-1:0] opened;
      wait_for_results();
      idle_on = 1'b0;
      write_csr(CSR_PUBLISH, CSR_MAX);
      write_csr(CSR_STALE, CSR_MAX);
      write_csr(CSR_EARLY, CSR_MAX);
      // open a fresh window well past the publish interval
      send_item(stamp_us + 48'h200_0000, 1'b1);
      opened = stamp_us;
      for (n = 0; n < 100; n++)
         send_item(stamp_us + 48'd1, 1'b1);
      send_item(opened + 48'(CSR_MAX), 1'b1);
      send_item(stamp_us + 48'd1, 1'b0);
      idle_on = 1'b1;
   endtask

   task automatic run_traffic(logic [CSR_BITS-1:0] pub, logic [CSR_BITS-1:0] stale,
                              logic [CSR_BITS-1:0] early, int unsigned dmax, int count);
      int                   n;
      int unsigned          roll;
      int unsigned          frame_pct;
      logic [TIME_BITS-1:0] step;
      wait_for_results();
      write_csr(CSR_PUBLISH, pub);
      write_csr(CSR_STALE, stale);
      write_csr(CSR_EARLY, early);
      frame_pct = 70;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            frame_pct = $urandom_range(20, 100);
            idle_on   = ($urandom_range(0, 3) != 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < 3)
            step = {1'b0, 15'($urandom), 32'($urandom)};
         else if (roll < 8)
            step = 48'(stale) + 48'd1 + 48'($urandom_range(0, dmax));
         else if (roll < 15)
            step = 48'($urandom_range(0, 3));
         else
            step = 48'($urandom_range(0, dmax));
         send_item(stamp_us + step, $urandom_range(0, 99) < frame_pct);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [CSR_BITS-1:0] pub;
      pub = CSR_BITS'($urandom_range(1, 32'hFF_FFFF));
      run_traffic(PUBLISH_RESET, STALE_RESET, EARLY_RESET, 40000, 180);
      run_traffic(24'd1000, 24'd3000, 24'd200, 400, 180);
      run_traffic(24'd1, 24'd1, 24'd1, 3, 180);
      run_traffic(CSR_MAX, CSR_MAX, CSR_MAX, 2000000, 180);
      run_traffic(24'd50000, 24'd20000, 24'd5000, 30000, 180);
      run_traffic(pub, CSR_BITS'($urandom_range(1, 32'hFF_FFFF)),
                  CSR_BITS'($urandom_range(1, pub)), 32'(pub) / 6 + 1, 180);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_window_lifecycle();
      test_zero_registers();
      test_saturation_and_wrap();
      test_backpressure();
      test_long_window();
      test_random_traffic();
      wait_for_results();
      $display("run covered %0d items and %0d register writes: window corners, time wrap,",
               items_sent, csr_writes);
      $display("rate saturation, long windows, output hold-off and random traffic");
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
